// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top level to check itself.
// No dependencies; take in by include ahead of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pfdc_pkg.sv -----
// Shared types and codes of the packet FIFO with duplicate check and range count.
// No dependencies; used by pfdc_ctrl and the top level.
package pfdc_pkg;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_FWD = 2'd1;
    localparam logic [1:0] OP_CNT = 2'd2;

    localparam int OP_W    = 2;
    localparam int MC_W    = 7;
    localparam int LIMIT_W = 7;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    // Controller status seen by the top-level checks.
    typedef struct packed {
        logic idle;
        logic fin;
        logic wr_en;
        logic occ_zero;
    } status_t;

endpackage

// ----- rtl/pfdc_mem.sv -----
// Packet store: single write port, single read port, registered read.
// No dependencies; instantiated by pfdc_ctrl's parent (top level).
module pfdc_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 70
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/pfdc_ctrl.sv -----
// Sequencer of the packet FIFO: request intake, scan of stored entries through the
// packet store, head/tail/occupancy upkeep and the result register. Uses pfdc_pkg.
module pfdc_ctrl #(
    parameter int DEPTH     = 64,
    parameter int ID_BITS   = 20,
    parameter int TIME_BITS = 30
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [pfdc_pkg::LIMIT_W-1:0]    memory_limit,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pfdc_pkg::OP_W-1:0]       s_tuser,
    input  logic [((2*ID_BITS+3*TIME_BITS+7)/8)*8-1:0] s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [((2*ID_BITS+TIME_BITS+pfdc_pkg::MC_W+2+7)/8)*8-1:0] m_tdata,
    output logic                            mem_we,
    output logic [$clog2(DEPTH)-1:0]        mem_waddr,
    output logic [2*ID_BITS+TIME_BITS-1:0]  mem_wdata,
    output logic                            mem_re,
    output logic [$clog2(DEPTH)-1:0]        mem_raddr,
    input  logic [2*ID_BITS+TIME_BITS-1:0]  mem_rdata,
    output pfdc_pkg::status_t               status
);

    localparam int AW    = $clog2(DEPTH);
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int EW    = (OCC_W > pfdc_pkg::LIMIT_W) ? OCC_W : pfdc_pkg::LIMIT_W;
    localparam int OUT_W = ((2*ID_BITS + TIME_BITS + pfdc_pkg::MC_W + 2 + 7) / 8) * 8;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]                  state_reg, state_next;
    logic [pfdc_pkg::OP_W-1:0]   op_reg, op_next;
    logic [ID_BITS-1:0]          src_reg, src_next;
    logic [ID_BITS-1:0]          dst_reg, dst_next;
    logic [TIME_BITS-1:0]        ts_reg, ts_next;
    logic [TIME_BITS-1:0]        t0_reg, t0_next;
    logic [TIME_BITS-1:0]        t1_reg, t1_next;
    logic [AW-1:0]               head_reg, head_next;
    logic [AW-1:0]               tail_reg, tail_next;
    logic [OCC_W-1:0]            occ_reg, occ_next;
    logic [OCC_W-1:0]            left_reg, left_next;
    logic [AW-1:0]               ptr_reg, ptr_next;
    logic                        rvld_reg, rvld_next;
    logic                        dup_reg, dup_next;
    logic [OCC_W-1:0]            cnt_reg, cnt_next;
    logic [ID_BITS-1:0]          fsrc_reg, fsrc_next;
    logic [ID_BITS-1:0]          fdst_reg, fdst_next;
    logic [TIME_BITS-1:0]        fts_reg, fts_next;
    logic                        mvld_reg, mvld_next;
    logic [OUT_W-1:0]            mdata_reg, mdata_next;

    logic [ID_BITS-1:0]          e_src, e_dst;
    logic [TIME_BITS-1:0]        e_ts;
    logic [EW-1:0]               lim_ext, eff_lim;
    logic                        at_limit, out_free, store_new;

    function automatic logic [AW-1:0] step_idx(input logic [AW-1:0] idx);
        logic [AW-1:0] r;
        if (idx == AW'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = idx + 1'b1;
        end
        return r;
    endfunction

    assign e_src = mem_rdata[ID_BITS-1:0];
    assign e_dst = mem_rdata[ID_BITS +: ID_BITS];
    assign e_ts  = mem_rdata[2*ID_BITS +: TIME_BITS];

    // Limit zero acts as one, above depth acts as depth.
    always_comb
    begin
        lim_ext = EW'(memory_limit);
        if (lim_ext == '0)
        begin
            eff_lim = EW'(1);
        end
        else if (lim_ext > EW'(DEPTH))
        begin
            eff_lim = EW'(DEPTH);
        end
        else
        begin
            eff_lim = lim_ext;
        end
    end

    assign at_limit  = (EW'(occ_reg) >= eff_lim) && (occ_reg != '0);
    assign out_free  = !mvld_reg || m_tready;
    assign store_new = (op_reg == pfdc_pkg::OP_ADD) && !dup_reg;

    assign s_tready  = (state_reg == S_IDLE);
    assign mem_re    = (state_reg == S_SCAN) && (left_reg != '0);
    assign mem_raddr = ptr_reg;
    assign mem_we    = (state_reg == S_FIN) && out_free && store_new;
    assign mem_waddr = tail_reg;
    assign mem_wdata = {ts_reg, dst_reg, src_reg};

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        ts_next    = ts_reg;
        t0_next    = t0_reg;
        t1_next    = t1_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        occ_next   = occ_reg;
        left_next  = left_reg;
        ptr_next   = ptr_reg;
        rvld_next  = 1'b0;
        dup_next   = dup_reg;
        cnt_next   = cnt_reg;
        fsrc_next  = fsrc_reg;
        fdst_next  = fdst_reg;
        fts_next   = fts_reg;
        mvld_next  = mvld_reg && !m_tready;
        mdata_next = mdata_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next  = s_tuser;
                    src_next = s_tdata[ID_BITS-1:0];
                    dst_next = s_tdata[ID_BITS +: ID_BITS];
                    ts_next  = s_tdata[2*ID_BITS +: TIME_BITS];
                    t0_next  = s_tdata[2*ID_BITS+TIME_BITS +: TIME_BITS];
                    t1_next  = s_tdata[2*ID_BITS+2*TIME_BITS +: TIME_BITS];
                    ptr_next = head_reg;
                    dup_next = 1'b0;
                    cnt_next = '0;
                    case (s_tuser)
                        pfdc_pkg::OP_ADD: left_next = occ_reg;
                        pfdc_pkg::OP_CNT: left_next = occ_reg;
                        pfdc_pkg::OP_FWD: left_next = OCC_W'(occ_reg != '0);
                        default:          left_next = '0;
                    endcase
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // Issue one read a cycle, compare the entry that returns.
                if (left_reg != '0)
                begin
                    ptr_next  = step_idx(ptr_reg);
                    left_next = left_reg - 1'b1;
                    rvld_next = 1'b1;
                end
                if (rvld_reg)
                begin
                    if (e_src == src_reg && e_dst == dst_reg && e_ts == ts_reg)
                    begin
                        dup_next = 1'b1;
                    end
                    if (e_dst == dst_reg && e_ts >= t0_reg && e_ts <= t1_reg)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    fsrc_next = e_src;
                    fdst_next = e_dst;
                    fts_next  = e_ts;
                end
                if (left_reg == '0 && !rvld_reg)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    mvld_next  = 1'b1;
                    mdata_next = '0;
                    case (op_reg)
                        pfdc_pkg::OP_ADD:
                        begin
                            if (!dup_reg)
                            begin
                                mdata_next[0] = 1'b1;
                                tail_next = step_idx(tail_reg);
                                if (at_limit)
                                begin
                                    // Evict oldest, occupancy holds.
                                    head_next = step_idx(head_reg);
                                end
                                else
                                begin
                                    occ_next = occ_reg + 1'b1;
                                end
                            end
                        end
                        pfdc_pkg::OP_FWD:
                        begin
                            if (occ_reg != '0)
                            begin
                                mdata_next[1] = 1'b1;
                                mdata_next[2 +: ID_BITS] = fsrc_reg;
                                mdata_next[2+ID_BITS +: ID_BITS] = fdst_reg;
                                mdata_next[2+2*ID_BITS +: TIME_BITS] = fts_reg;
                                head_next = step_idx(head_reg);
                                occ_next  = occ_reg - 1'b1;
                            end
                        end
                        pfdc_pkg::OP_CNT:
                        begin
                            mdata_next[2+2*ID_BITS+TIME_BITS +: pfdc_pkg::MC_W] =
                                pfdc_pkg::MC_W'(cnt_reg);
                        end
                        default:
                        begin
                            mdata_next = '0;
                        end
                    endcase
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            occ_reg   <= '0;
            left_reg  <= '0;
            rvld_reg  <= 1'b0;
            mvld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            occ_reg   <= occ_next;
            left_reg  <= left_next;
            rvld_reg  <= rvld_next;
            mvld_reg  <= mvld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        src_reg   <= src_next;
        dst_reg   <= dst_next;
        ts_reg    <= ts_next;
        t0_reg    <= t0_next;
        t1_reg    <= t1_next;
        ptr_reg   <= ptr_next;
        dup_reg   <= dup_next;
        cnt_reg   <= cnt_next;
        fsrc_reg  <= fsrc_next;
        fdst_reg  <= fdst_next;
        fts_reg   <= fts_next;
        mdata_reg <= mdata_next;
    end

    assign m_tvalid = mvld_reg;
    assign m_tdata  = mdata_reg;

    assign status.idle     = (state_reg == S_IDLE);
    assign status.fin      = (state_reg == S_FIN);
    assign status.wr_en    = mem_we;
    assign status.occ_zero = (occ_reg == '0);

endmodule

// ----- rtl/packet_fifo_dedup_range_count_top.sv -----
// Sequence: a request is accepted only in idle; the sequencer then reads N entries (occupancy
// for add and count, 1 for forward of a nonempty buffer), one entry per cycle from the
// packet store, checks each returned entry and registers the result at its finish step.
// A new request is taken only after the finish step; a waiting result holds it there.
// Reset: asynchronous, active low; empties the buffer and sets memory_limit to 64.
// Top level: configuration register, packet store and sequencer. Uses pfdc_pkg,
// pfdc_mem, pfdc_ctrl and assert_macros.svh.
`include "assert_macros.svh"

module packet_fifo_dedup_range_count_top #(
    parameter int DEPTH     = 64,
    parameter int ID_BITS   = 20,
    parameter int TIME_BITS = 30
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // requests
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tuser: operation
    input  logic [pfdc_pkg::OP_W-1:0] s_tuser,
    // s_tdata: source, destination, timestamp, start_time, end_time, zero pad
    input  logic [((2*ID_BITS+3*TIME_BITS+7)/8)*8-1:0] s_tdata,
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: added, packet_valid, out_source, out_destination, out_timestamp,
    //          match_count, zero pad
    output logic [((2*ID_BITS+TIME_BITS+pfdc_pkg::MC_W+2+7)/8)*8-1:0] m_tdata
);

    localparam int AW    = $clog2(DEPTH);
    localparam int ENT_W = 2*ID_BITS + TIME_BITS;

    logic [pfdc_pkg::LIMIT_W-1:0] limit_reg, limit_next;
    logic                         mem_we, mem_re;
    logic [AW-1:0]                mem_waddr, mem_raddr;
    logic [ENT_W-1:0]             mem_wdata, mem_rdata;
    pfdc_pkg::status_t            status;

    assign pready = 1'b1;

    always_comb
    begin
        limit_next = limit_reg;
        if (psel && penable && pwrite && !paddr[2])
        begin
            limit_next = pwdata[pfdc_pkg::LIMIT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= pfdc_pkg::LIMIT_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    assign prdata = paddr[2] ? 32'd0 : 32'(limit_reg);

    pfdc_mem #(
        .DEPTH (DEPTH),
        .WIDTH (ENT_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    pfdc_ctrl #(
        .DEPTH     (DEPTH),
        .ID_BITS   (ID_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .memory_limit (limit_reg),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tuser      (s_tuser),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata),
        .status       (status)
    );

    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !status.idle, "not busy")
    `ASSERT_SAME(a_write_at_finish, clk, rst_n, status.wr_en, status.fin, "write outside finish")
    `ASSERT_NEXT(a_nonempty_after_add, clk, rst_n, status.wr_en, !status.occ_zero, "empty after add")

endmodule
